FILE: rtl/sfla_pkg.sv
package sfla_pkg;

	// default sizes
	localparam int FREE_ENTRIES_DEF = 16;
	localparam int ID_COUNT_DEF     = 16;
	localparam int ADDR_BITS_DEF    = 16;

	// fixed field widths
	localparam int START_W = 16;
	localparam int SIZE_W  = 17;
	localparam int USED_W  = START_W + SIZE_W;

	// internal value width: holds start + size of any request
	localparam int VAL_W = 18;
	// cell position width: up to 511 cells plus one past the end
	localparam int POS_W = 9;

	localparam logic [VAL_W-1:0] RST_TOTAL = VAL_W'(1024);

	typedef enum logic [1:0] {
		ACT_CREATE = 2'd0,
		ACT_REMOVE = 2'd1,
		ACT_FIND   = 2'd2,
		ACT_BAD    = 2'd3
	} action_t;

	typedef enum logic [1:0] {
		POL_FIRST = 2'd0,
		POL_BEST  = 2'd1,
		POL_WORST = 2'd2,
		POL_BAD   = 2'd3
	} policy_t;

	typedef enum logic [2:0] {
		ST_OK       = 3'd0,
		ST_INVALID  = 3'd1,
		ST_NOSPACE  = 3'd2,
		ST_INUSE    = 3'd3,
		ST_NOTFOUND = 3'd4,
		ST_FULL     = 3'd5
	} status_t;

	// row commands
	typedef enum logic [2:0] {
		OP_NONE  = 3'd0,
		OP_CLR   = 3'd1,
		OP_WR    = 3'd2,
		OP_DEL   = 3'd3,
		OP_INS   = 3'd4,
		OP_SPLIT = 3'd5,
		OP_MERGE = 3'd6
	} op_t;

	typedef struct packed {
		logic             valid;
		logic [VAL_W-1:0] start;
		logic [VAL_W-1:0] size;
	} ent_t;

	typedef struct packed {
		logic [VAL_W-1:0] s;
		logic [VAL_W-1:0] z;
		logic [VAL_W-1:0] se;
	} qry_t;

	typedef struct packed {
		logic contains;
		logic fits;
		logic lt;
		logic end_eq;
		logic start_eq;
	} flg_t;

	typedef struct packed {
		op_t              op;
		logic [POS_W-1:0] pos;
		logic [VAL_W-1:0] a_start;
		logic [VAL_W-1:0] a_size;
		logic [VAL_W-1:0] b_start;
		logic [VAL_W-1:0] b_size;
	} cmd_t;

endpackage

FILE: rtl/sfla_ram.sv
module sfla_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16,
	localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
	input  logic             clk,
	input  logic             we,
	input  logic [AW-1:0]    waddr,
	input  logic [WIDTH-1:0] wdata,
	input  logic [AW-1:0]    raddr,
	output logic [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

FILE: rtl/sfla_cell.sv
module sfla_cell #(
	parameter int IDX = 0,
	parameter logic [sfla_pkg::VAL_W-1:0] RST_SIZE = sfla_pkg::RST_TOTAL
) (
	input  logic            clk,
	input  logic            arst_n,
	input  sfla_pkg::cmd_t  cmd,
	input  sfla_pkg::qry_t  qry,
	input  sfla_pkg::ent_t  left_i,
	input  sfla_pkg::ent_t  right_i,
	output sfla_pkg::ent_t  ent_o,
	output sfla_pkg::flg_t  flg_o
);

	localparam logic [sfla_pkg::POS_W-1:0] ME = sfla_pkg::POS_W'(IDX);

	sfla_pkg::ent_t              ent_q;
	sfla_pkg::ent_t              nxt;
	logic [sfla_pkg::POS_W-1:0]  pos1;
	logic [sfla_pkg::VAL_W-1:0]  seg_end;

	assign pos1    = cmd.pos + sfla_pkg::POS_W'(1);
	assign seg_end = ent_q.start + ent_q.size;

	always_comb begin
		nxt = ent_q;
		case (cmd.op)
			sfla_pkg::OP_CLR: begin
				nxt.start = '0;
				if (IDX == 0) begin
					nxt.valid = (cmd.a_size != '0);
					nxt.size  = cmd.a_size;
				end else begin
					nxt.valid = 1'b0;
					nxt.size  = '0;
				end
			end
			sfla_pkg::OP_WR: begin
				if (ME == cmd.pos) begin
					nxt.start = cmd.a_start;
					nxt.size  = cmd.a_size;
				end
			end
			sfla_pkg::OP_DEL: begin
				if (ME >= cmd.pos) nxt = right_i;
			end
			sfla_pkg::OP_INS: begin
				if (ME == cmd.pos) begin
					nxt.valid = 1'b1;
					nxt.start = cmd.a_start;
					nxt.size  = cmd.a_size;
				end else if (ME > cmd.pos) begin
					nxt = left_i;
				end
			end
			sfla_pkg::OP_SPLIT: begin
				if (ME == cmd.pos) begin
					nxt.start = cmd.a_start;
					nxt.size  = cmd.a_size;
				end else if (ME == pos1) begin
					nxt.valid = 1'b1;
					nxt.start = cmd.b_start;
					nxt.size  = cmd.b_size;
				end else if (ME > pos1) begin
					nxt = left_i;
				end
			end
			sfla_pkg::OP_MERGE: begin
				if (ME == cmd.pos) begin
					nxt.start = cmd.a_start;
					nxt.size  = cmd.a_size;
				end else if (ME > cmd.pos) begin
					nxt = right_i;
				end
			end
			default: nxt = ent_q;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ent_q.valid <= (IDX == 0);
			ent_q.start <= '0;
			ent_q.size  <= (IDX == 0) ? RST_SIZE : '0;
		end else begin
			ent_q <= nxt;
		end
	end

	// local compares against the broadcast query
	always_comb begin
		flg_o.contains = ent_q.valid && (ent_q.start <= qry.s) && (seg_end >= qry.se);
		flg_o.fits     = ent_q.valid && (ent_q.size >= qry.z);
		flg_o.lt       = ent_q.valid && (ent_q.start < qry.s);
		flg_o.end_eq   = ent_q.valid && (seg_end == qry.s);
		flg_o.start_eq = ent_q.valid && (ent_q.start == qry.se);
	end

	assign ent_o = ent_q;

endmodule

FILE: rtl/segment_free_list_allocator.sv
// Segment free-list allocator. One beat enters when start is high and busy is
// low; exactly one result beat follows, shown on status and found_address for
// a single cycle while done is high. The receiver cannot stall: the result
// must be taken in the cycle done is high. Busy is high from the accepting
// edge until the edge that raises done, so the next beat can go in during the
// done cycle. Create, first-fit find and rejected requests finish in S_EVAL;
// remove goes on to S_REM (S_EVAL loads the allocation-table read, S_REM
// makes the merge decision); best/worst-fit find goes on to S_SCAN, which
// visits one free entry per cycle until the first empty one or the last cell.
// Free segments live in a row of FREE_ENTRIES cells kept sorted by start and
// packed toward cell 0. Each cell compares itself against the broadcast
// request; deletes and inserts shift the cells from the given position on
// one place left or right, all in the same cycle. Allocations sit in a small
// RAM indexed by alloc_id with valid bits in flops. A write of span_units
// (cfg_we) resets the row to one segment covering [0,span_units), clipped to
// 2^ADDR_BITS, and drops all allocations; write it only while idle.
module segment_free_list_allocator #(
	parameter int FREE_ENTRIES = sfla_pkg::FREE_ENTRIES_DEF,
	parameter int ID_COUNT     = sfla_pkg::ID_COUNT_DEF,
	parameter int ADDR_BITS    = sfla_pkg::ADDR_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	// config
	input  logic        cfg_we,
	input  logic [16:0] span_units,
	// request
	input  logic        start,
	output logic        busy,
	input  logic [1:0]  action,
	input  logic [3:0]  alloc_id,
	input  logic [15:0] seg_start,
	input  logic [16:0] seg_size,
	input  logic [1:0]  fit_policy,
	// result
	output logic        done,
	output logic [2:0]  status,
	output logic [15:0] found_address
);

	localparam int VW = sfla_pkg::VAL_W;
	localparam int PW = sfla_pkg::POS_W;
	localparam int SW = $clog2(FREE_ENTRIES);
	localparam int IW = (ID_COUNT > 1) ? $clog2(ID_COUNT) : 1;
	localparam logic [31:0] LIM = 32'd1 << ADDR_BITS;
	localparam logic [VW-1:0] RST_SIZE =
		(32'(sfla_pkg::RST_TOTAL) > LIM) ? VW'(LIM) : sfla_pkg::RST_TOTAL;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_EVAL = 4'b0010,
		S_REM  = 4'b0100,
		S_SCAN = 4'b1000
	} state_t;

	state_t state_q, nstate;

	// latched request
	sfla_pkg::action_t act_q;
	sfla_pkg::policy_t pol_q;
	logic [3:0]        id_q;
	logic [VW-1:0]     s_q, z_q, se_q;

	// scan state
	logic [SW-1:0]     idx_q;
	logic              have_q;
	logic [VW-1:0]     best_size_q, best_start_q;

	// allocations
	logic [ID_COUNT-1:0]          used_valid_q;
	logic [sfla_pkg::USED_W-1:0]  rd_data;
	logic [IW-1:0]                id_idx;

	// result
	logic                 done_q;
	sfla_pkg::status_t    status_q;
	logic [15:0]          addr_q;

	// row
	sfla_pkg::ent_t  ent [FREE_ENTRIES];
	sfla_pkg::flg_t  flg [FREE_ENTRIES];
	sfla_pkg::cmd_t  cmd, op_cmd;
	sfla_pkg::qry_t  qry;

	logic accept;

	// decision outputs
	logic              fin, ram_we, set_used, clr_used, load_rem, scan_init, scan_step;
	sfla_pkg::status_t st;
	logic [15:0]       addr_n;
	logic              take;

	// clipped total for a config write
	logic [31:0]   tot32;
	logic [VW-1:0] clr_size;

	// gathered flags and picks
	logic [FREE_ENTRIES-1:0] cont_v, fits_v, lt_v, endq_v, stq_v;
	logic [FREE_ENTRIES-1:0] hit_v, ff_v, pz_v;
	logic [PW-1:0]           hit_idx, pv_idx, nx_idx, p_idx;
	logic [VW-1:0]           hit_start, hit_size, ff_start;
	logic [VW-1:0]           pv_start, pv_size, nx_size;
	logic                    full, used_v, id_ok, bad;
	logic [VW-1:0]           hit_end;
	sfla_pkg::ent_t          cur;
	logic [VW-1:0]           rd_start, rd_size;

	assign busy   = (state_q != S_IDLE);
	assign accept = start && !busy;
	assign id_idx = IW'(id_q);

	assign qry.s  = s_q;
	assign qry.z  = z_q;
	assign qry.se = se_q;

	assign tot32    = {15'b0, span_units};
	assign clr_size = (tot32 > LIM) ? VW'(LIM) : VW'(tot32);

	// config write overrides the sequencer (the user must write it only while idle; the block does not enforce this)
	always_comb begin
		cmd = op_cmd;
		if (cfg_we) begin
			cmd        = '0;
			cmd.op     = sfla_pkg::OP_CLR;
			cmd.a_size = clr_size;
		end
	end

	genvar k;
	generate
		for (k = 0; k < FREE_ENTRIES; k++) begin : g_cell
			sfla_pkg::ent_t lft, rgt;
			if (k == 0) begin : g_first
				assign lft = '0;
			end else begin : g_mid
				assign lft = ent[k-1];
			end
			if (k == FREE_ENTRIES - 1) begin : g_last
				assign rgt = '0;
			end else begin : g_next
				assign rgt = ent[k+1];
			end
			sfla_cell #(
				.IDX      (k),
				.RST_SIZE (RST_SIZE)
			) u_cell (
				.clk     (clk),
				.arst_n  (arst_n),
				.cmd     (cmd),
				.qry     (qry),
				.left_i  (lft),
				.right_i (rgt),
				.ent_o   (ent[k]),
				.flg_o   (flg[k])
			);
		end
	endgenerate

	// allocation table: {start, size} per id
	sfla_ram #(
		.WIDTH (sfla_pkg::USED_W),
		.DEPTH (ID_COUNT)
	) u_used (
		.clk   (clk),
		.we    (ram_we),
		.waddr (id_idx),
		.wdata ({s_q[15:0], z_q[16:0]}),
		.raddr (IW'(alloc_id)),
		.rdata (rd_data)
	);

	assign rd_start = VW'(rd_data[sfla_pkg::USED_W-1:sfla_pkg::SIZE_W]);
	assign rd_size  = VW'(rd_data[sfla_pkg::SIZE_W-1:0]);

	// gather cell flags; picks are one-hot so AND-OR selection suffices
	always_comb begin
		for (int i = 0; i < FREE_ENTRIES; i++) begin
			cont_v[i] = flg[i].contains;
			fits_v[i] = flg[i].fits;
			lt_v[i]   = flg[i].lt;
			endq_v[i] = flg[i].end_eq;
			stq_v[i]  = flg[i].start_eq;
		end
		hit_v = cont_v & (~cont_v + 1'b1);
		ff_v  = fits_v & (~fits_v + 1'b1);
		// lt is a prefix of the sorted row: first zero is the insert point
		pz_v  = ~lt_v & (lt_v + 1'b1);
		hit_idx = '0; pv_idx = '0; nx_idx = '0;
		p_idx   = (pz_v == '0) ? PW'(FREE_ENTRIES) : '0;
		hit_start = '0; hit_size = '0; ff_start = '0;
		pv_start  = '0; pv_size  = '0; nx_size  = '0;
		for (int i = 0; i < FREE_ENTRIES; i++) begin
			if (hit_v[i]) begin
				hit_idx   = hit_idx | PW'(i);
				hit_start = hit_start | ent[i].start;
				hit_size  = hit_size | ent[i].size;
			end
			if (ff_v[i]) ff_start = ff_start | ent[i].start;
			if (endq_v[i]) begin
				pv_idx   = pv_idx | PW'(i);
				pv_start = pv_start | ent[i].start;
				pv_size  = pv_size | ent[i].size;
			end
			if (stq_v[i]) begin
				nx_idx  = nx_idx | PW'(i);
				nx_size = nx_size | ent[i].size;
			end
			if (pz_v[i]) p_idx = p_idx | PW'(i);
		end
	end

	assign full    = ent[FREE_ENTRIES-1].valid;
	assign hit_end = hit_start + hit_size;
	assign used_v  = used_valid_q[id_idx];
	assign id_ok   = (int'(id_q) < ID_COUNT);
	assign cur     = ent[idx_q];

	always_comb begin
		case (act_q)
			sfla_pkg::ACT_CREATE: bad = (z_q == '0) || !id_ok;
			sfla_pkg::ACT_REMOVE: bad = !id_ok;
			sfla_pkg::ACT_FIND:   bad = (z_q == '0) || (pol_q == sfla_pkg::POL_BAD);
			default:              bad = 1'b1;
		endcase
	end

	assign take = cur.valid && (cur.size >= z_q) &&
		(!have_q ||
		 ((pol_q == sfla_pkg::POL_BEST) && (cur.size < best_size_q)) ||
		 ((pol_q == sfla_pkg::POL_WORST) && (cur.size > best_size_q)));

	// sequencer
	always_comb begin
		nstate    = state_q;
		fin       = 1'b0;
		st        = sfla_pkg::ST_OK;
		addr_n    = '0;
		op_cmd    = '0;
		ram_we    = 1'b0;
		set_used  = 1'b0;
		clr_used  = 1'b0;
		load_rem  = 1'b0;
		scan_init = 1'b0;
		scan_step = 1'b0;
		case (state_q)
			S_IDLE: begin
				if (accept) nstate = S_EVAL;
			end
			S_EVAL: begin
				nstate = S_IDLE;
				fin    = 1'b1;
				if (bad) begin
					st = sfla_pkg::ST_INVALID;
				end else if (act_q == sfla_pkg::ACT_CREATE) begin
					if (cont_v == '0) begin
						st = sfla_pkg::ST_NOSPACE;
					end else if (used_v) begin
						st = sfla_pkg::ST_INUSE;
					end else begin
						op_cmd.pos = hit_idx;
						if (hit_start == s_q && hit_end == se_q) begin
							op_cmd.op = sfla_pkg::OP_DEL;
						end else if (hit_start == s_q) begin
							op_cmd.op      = sfla_pkg::OP_WR;
							op_cmd.a_start = se_q;
							op_cmd.a_size  = hit_end - se_q;
						end else if (hit_end == se_q) begin
							op_cmd.op      = sfla_pkg::OP_WR;
							op_cmd.a_start = hit_start;
							op_cmd.a_size  = s_q - hit_start;
						end else if (!full) begin
							op_cmd.op      = sfla_pkg::OP_SPLIT;
							op_cmd.a_start = hit_start;
							op_cmd.a_size  = s_q - hit_start;
							op_cmd.b_start = se_q;
							op_cmd.b_size  = hit_end - se_q;
						end
						if (op_cmd.op == sfla_pkg::OP_NONE) begin
							st = sfla_pkg::ST_FULL;
						end else begin
							ram_we   = 1'b1;
							set_used = 1'b1;
						end
					end
				end else if (act_q == sfla_pkg::ACT_REMOVE) begin
					if (!used_v) begin
						st = sfla_pkg::ST_NOTFOUND;
					end else begin
						fin      = 1'b0;
						load_rem = 1'b1;
						nstate   = S_REM;
					end
				end else if (pol_q == sfla_pkg::POL_FIRST) begin
					if (fits_v == '0) begin
						st = sfla_pkg::ST_NOSPACE;
					end else begin
						addr_n = ff_start[15:0];
					end
				end else begin
					fin       = 1'b0;
					scan_init = 1'b1;
					nstate    = S_SCAN;
				end
			end
			S_REM: begin
				nstate = S_IDLE;
				fin    = 1'b1;
				if ((stq_v != '0) && (endq_v != '0)) begin
					op_cmd.op      = sfla_pkg::OP_MERGE;
					op_cmd.pos     = pv_idx;
					op_cmd.a_start = pv_start;
					op_cmd.a_size  = pv_size + z_q + nx_size;
				end else if (endq_v != '0) begin
					op_cmd.op      = sfla_pkg::OP_WR;
					op_cmd.pos     = pv_idx;
					op_cmd.a_start = pv_start;
					op_cmd.a_size  = pv_size + z_q;
				end else if (stq_v != '0) begin
					op_cmd.op      = sfla_pkg::OP_WR;
					op_cmd.pos     = nx_idx;
					op_cmd.a_start = s_q;
					op_cmd.a_size  = nx_size + z_q;
				end else if (!full) begin
					op_cmd.op      = sfla_pkg::OP_INS;
					op_cmd.pos     = p_idx;
					op_cmd.a_start = s_q;
					op_cmd.a_size  = z_q;
				end
				if (op_cmd.op == sfla_pkg::OP_NONE) begin
					st = sfla_pkg::ST_FULL;
				end else begin
					clr_used = 1'b1;
				end
			end
			S_SCAN: begin
				scan_step = 1'b1;
				if (!cur.valid || idx_q == SW'(FREE_ENTRIES - 1)) begin
					nstate = S_IDLE;
					fin    = 1'b1;
					if (take) begin
						addr_n = cur.start[15:0];
					end else if (have_q) begin
						addr_n = best_start_q[15:0];
					end else begin
						st = sfla_pkg::ST_NOSPACE;
					end
				end
			end
			default: nstate = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= S_IDLE;
			done_q       <= 1'b0;
			status_q     <= sfla_pkg::ST_OK;
			addr_q       <= '0;
			used_valid_q <= '0;
			idx_q        <= '0;
			have_q       <= 1'b0;
		end else begin
			state_q <= nstate;
			done_q  <= fin;
			if (fin) begin
				status_q <= st;
				addr_q   <= addr_n;
			end
			if (cfg_we) begin
				used_valid_q <= '0;
			end else if (set_used) begin
				used_valid_q[id_idx] <= 1'b1;
			end else if (clr_used) begin
				used_valid_q[id_idx] <= 1'b0;
			end
			if (scan_init) begin
				idx_q  <= '0;
				have_q <= 1'b0;
			end else if (scan_step) begin
				idx_q <= idx_q + SW'(1);
				if (take) have_q <= 1'b1;
			end
		end
	end

	// payload
	always_ff @(posedge clk) begin
		if (accept) begin
			act_q <= sfla_pkg::action_t'(action);
			pol_q <= sfla_pkg::policy_t'(fit_policy);
			id_q  <= alloc_id;
			s_q   <= VW'(seg_start);
			z_q   <= VW'(seg_size);
			se_q  <= VW'(seg_start) + VW'(seg_size);
		end else if (load_rem) begin
			s_q  <= rd_start;
			z_q  <= rd_size;
			se_q <= rd_start + rd_size;
		end
		if (scan_step && take) begin
			best_size_q  <= cur.size;
			best_start_q <= cur.start;
		end
	end

	assign done          = done_q;
	assign status        = status_q;
	assign found_address = addr_q;

endmodule

FILE: dv/tb_segment_free_list_allocator.sv
`timescale 1ns / 1ps

module tb_segment_free_list_allocator;
	import sfla_pkg::*;

	localparam int NFREE  = 16;
	localparam int NID    = 16;
	localparam int SPAN   = 65536;   // 2^ADDR_BITS
	// give the tail some slack
	localparam int DRAIN_CYCLES = 40;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_we = 1'b0;
	logic [16:0] span_units = 17'd0;
	logic        start = 1'b0;
	logic        busy;
	logic [1:0]  action = 2'd0;
	logic [3:0]  alloc_id = 4'd0;
	logic [15:0] seg_start = 16'd0;
	logic [16:0] seg_size = 17'd0;
	logic [1:0]  fit_policy = 2'd0;
	logic        done;
	logic [2:0]  status;
	logic [15:0] found_address;

	segment_free_list_allocator u_top (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .span_units(span_units),
		.start(start), .busy(busy),
		.action(action), .alloc_id(alloc_id), .seg_start(seg_start),
		.seg_size(seg_size), .fit_policy(fit_policy),
		.done(done), .status(status), .found_address(found_address)
	);

	// one pending beat: either a request or a size write
	typedef struct {
		bit          is_size_wr;
		bit   [16:0] size_val;
		bit   [1:0]  act;
		bit   [3:0]  id;
		bit   [15:0] s;
		bit   [16:0] z;
		bit   [1:0]  pol;
		int          idle_pct;   // chance the sender sits out a cycle
	} req_t;

	typedef struct {
		status_t     st;
		bit   [15:0] addr;
	} answer_t;

	req_t    req_q[$];
	answer_t answer_q[$];

	int errors = 0;
	int n_req = 0;
	int n_ans = 0;
	int n_size_wr = 0;
	bit stim_loaded = 0;

	// -------------------------------------------------------------------
	// Allocator shadow: free table sorted by start and packed low, plus
	// the allocation table indexed by id.
	// -------------------------------------------------------------------
	bit [16:0] sh_total;
	bit [16:0] fr_start[NFREE];   // 17 bits so start+size never wraps
	bit [16:0] fr_size[NFREE];
	bit        fr_valid[NFREE];
	bit [15:0] us_start[NID];
	bit [16:0] us_size[NID];
	bit        us_valid[NID];

	function automatic void shadow_init(bit [16:0] v);
		sh_total = v;
		for (int i = 0; i < NFREE; i++) begin
			fr_start[i] = '0; fr_size[i] = '0; fr_valid[i] = 0;
		end
		for (int i = 0; i < NID; i++) begin
			us_start[i] = '0; us_size[i] = '0; us_valid[i] = 0;
		end
		// values past the address space clip to it
		if (v != 0) begin
			fr_size[0] = (v > SPAN) ? 17'(SPAN) : v;
			fr_valid[0] = 1;
		end
	endfunction

	function automatic int free_count();
		int n;
		n = 0;
		while (n < NFREE && fr_valid[n]) n++;
		return n;
	endfunction

	function automatic void free_insert(int n, int p, bit [16:0] s, bit [16:0] z);
		for (int k = n; k > p; k--) begin
			fr_start[k] = fr_start[k-1];
			fr_size[k]  = fr_size[k-1];
		end
		fr_start[p] = s;
		fr_size[p]  = z;
		fr_valid[n] = 1;
	endfunction

	function automatic void free_delete(int n, int p);
		for (int k = p; k + 1 < n; k++) begin
			fr_start[k] = fr_start[k+1];
			fr_size[k]  = fr_size[k+1];
		end
		fr_start[n-1] = '0;
		fr_size[n-1]  = '0;
		fr_valid[n-1] = 0;
	endfunction

	function automatic status_t claim_segment(bit [3:0] id, bit [15:0] s, bit [16:0] z);
		int n, hit;
		int unsigned b, e, re;
		n = free_count();
		hit = -1;
		re = s + z;
		if (z == 0) return ST_INVALID;
		for (int i = 0; i < n; i++) begin
			if (fr_start[i] <= s && fr_start[i] + fr_size[i] >= re) begin
				hit = i;
				break;
			end
		end
		if (hit < 0) return ST_NOSPACE;
		if (us_valid[id]) return ST_INUSE;
		b = fr_start[hit];
		e = b + fr_size[hit];
		if (b == s && e == re) begin
			free_delete(n, hit);
		end else if (b == s) begin
			fr_start[hit] = 17'(re);
			fr_size[hit]  = 17'(e - re);
		end else if (e == re) begin
			fr_size[hit] = 17'(s - b);
		end else begin
			// middle split needs a spare free entry
			if (n >= NFREE) return ST_FULL;
			free_insert(n, hit + 1, 17'(re), 17'(e - re));
			fr_size[hit] = 17'(s - b);
		end
		us_start[id] = s;
		us_size[id]  = z;
		us_valid[id] = 1;
		return ST_OK;
	endfunction

	function automatic status_t release_segment(bit [3:0] id);
		int n, p;
		bit [16:0] s, z;
		bit nx, pv;
		n = free_count();
		p = 0;
		if (!us_valid[id]) return ST_NOTFOUND;
		s = us_start[id];
		z = us_size[id];
		while (p < n && fr_start[p] < s) p++;
		nx = (p < n) && (s + z == fr_start[p]);
		pv = (p > 0) && (fr_start[p-1] + fr_size[p-1] == s);
		if (nx && pv) begin
			fr_size[p-1] = fr_size[p-1] + z + fr_size[p];
			free_delete(n, p);
		end else if (pv) begin
			fr_size[p-1] = fr_size[p-1] + z;
		end else if (nx) begin
			fr_start[p] = s;
			fr_size[p]  = fr_size[p] + z;
		end else begin
			// isolated hole and no room: allocation stays put
			if (n >= NFREE) return ST_FULL;
			free_insert(n, p, s, z);
		end
		us_valid[id] = 0;
		return ST_OK;
	endfunction

	function automatic answer_t fit_search(bit [16:0] z, bit [1:0] pol);
		answer_t r;
		int n, pick;
		n = free_count();
		pick = -1;
		r.st = ST_OK;
		r.addr = '0;
		if (z == 0 || pol == POL_BAD) begin
			r.st = ST_INVALID;
			return r;
		end
		for (int i = 0; i < n; i++) begin
			if (fr_size[i] < z) continue;
			if (pick < 0) begin
				pick = i;
				if (pol == POL_FIRST) break;
			end else if (pol == POL_BEST && fr_size[i] < fr_size[pick]) begin
				pick = i;   // strict compare keeps the lowest on ties
			end else if (pol == POL_WORST && fr_size[i] > fr_size[pick]) begin
				pick = i;
			end
		end
		if (pick < 0) r.st = ST_NOSPACE;
		else r.addr = fr_start[pick][15:0];
		return r;
	endfunction

	function automatic answer_t allocator_answer(bit [1:0] a, bit [3:0] id, bit [15:0] s,
			bit [16:0] z, bit [1:0] pol);
		answer_t r;
		r.st = ST_INVALID;
		r.addr = '0;
		case (a)
			ACT_CREATE: r.st = claim_segment(id, s, z);
			ACT_REMOVE: r.st = release_segment(id);
			ACT_FIND:   r = fit_search(z, pol);
			default:    r.st = ST_INVALID;
		endcase
		if (r.st != ST_OK) r.addr = '0;
		return r;
	endfunction

	task automatic report(string what, status_t got_st, bit [15:0] got_a, answer_t want);
		errors++;
		$display("[%0t] MISMATCH %s: got status %0d addr %0d, want status %0d addr %0d",
			$time, what, got_st, got_a, want.st, want.addr);
	endtask

	// -------------------------------------------------------------------
	// Clock and reset
	// -------------------------------------------------------------------
	initial begin
		forever #5 clk = ~clk;
	end

	initial begin
		repeat (8) @(posedge clk);
		arst_n <= 1'b1;
	end

	// -------------------------------------------------------------------
	// Driver. Inputs change only at the rising edge; the accept test uses
	// the values that were on the ports just before the edge. Each output
	// gets one nonblocking write per edge, chosen through the nxt_ temps.
	// -------------------------------------------------------------------
	logic nxt_start, nxt_we;
	int   quiet_cycles = 0;
	req_t cur;

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			start  <= 1'b0;
			cfg_we <= 1'b0;
			shadow_init(17'(RST_TOTAL));
		end else begin
			// size write lands at this edge
			if (cfg_we) shadow_init(span_units);
			// request beat taken at this edge
			if (start && !busy) begin
				answer_q.push_back(allocator_answer(action, alloc_id, seg_start, seg_size,
					fit_policy));
				n_req++;
			end

			if (answer_q.size() == 0 && !busy && !start && !cfg_we) quiet_cycles++;
			else quiet_cycles = 0;

			nxt_start = 1'b0;
			nxt_we = 1'b0;
			if (start && busy) begin
				nxt_start = 1'b1;   // hold the beat until it is taken
			end else if (req_q.size() > 0) begin
				cur = req_q[0];
				if (cur.is_size_wr) begin
					// only write while the block is fully idle
					if (quiet_cycles >= 4) begin
						nxt_we = 1'b1;
						span_units <= cur.size_val;
						n_size_wr++;
						void'(req_q.pop_front());
					end
				end else if ($urandom_range(0, 99) >= cur.idle_pct) begin
					nxt_start = 1'b1;
					action     <= cur.act;
					alloc_id   <= cur.id;
					seg_start  <= cur.s;
					seg_size   <= cur.z;
					fit_policy <= cur.pol;
					void'(req_q.pop_front());
				end
			end
			start  <= nxt_start;
			cfg_we <= nxt_we;
		end
	end

	// -------------------------------------------------------------------
	// Monitor: a result is present only in the cycle done is high.
	// -------------------------------------------------------------------
	answer_t want;
	always @(posedge clk) begin
		if (arst_n && done) begin
			n_ans++;
			if (answer_q.size() == 0) begin
				want.st = ST_OK;
				want.addr = '0;
				report("unexpected result beat", status_t'(status), found_address, want);
			end else begin
				want = answer_q.pop_front();
				if (status !== want.st)
					report("status", status_t'(status), found_address, want);
				else if (found_address !== want.addr)
					report("found_address", status_t'(status), found_address, want);
			end
		end
	end

	// -------------------------------------------------------------------
	// Stimulus
	// -------------------------------------------------------------------
	int ph_idle;
	int unsigned ph_total;   // clipped span of the current phase

	task automatic push_req(bit [1:0] a, bit [3:0] id, bit [15:0] s, bit [16:0] z,
			bit [1:0] pol);
		req_t r;
		r.is_size_wr = 0; r.size_val = '0;
		r.act = a; r.id = id; r.s = s; r.z = z; r.pol = pol;
		r.idle_pct = ph_idle;
		req_q.push_back(r);
	endtask

	task automatic push_size(bit [16:0] v, int idle);
		req_t r;
		r.is_size_wr = 1; r.size_val = v;
		r.act = '0; r.id = '0; r.s = '0; r.z = '0; r.pol = '0;
		r.idle_pct = idle;
		req_q.push_back(r);
		ph_idle = idle;
		ph_total = (v > SPAN) ? SPAN : v;
	endtask

	// mostly legal creates/removes/finds over the current span, some noise
	task automatic push_random(int count);
		int r;
		int unsigned s, room, z;
		for (int k = 0; k < count; k++) begin
			r = $urandom_range(0, 99);
			if (r < 45 && ph_total > 0) begin
				s = $urandom_range(0, ph_total - 1);
				room = ph_total - s;
				if ($urandom_range(0, 9) == 0) z = $urandom_range(1, room);
				else z = $urandom_range(1, (room < 24) ? room : 24);
				push_req(ACT_CREATE, 4'($urandom), 16'(s), 17'(z), 2'($urandom));
			end else if (r < 72) begin
				push_req(ACT_REMOVE, 4'($urandom), 16'($urandom), 17'($urandom),
					2'($urandom));
			end else if (r < 90) begin
				z = (ph_total > 0) ? $urandom_range(1, (ph_total < 64) ? ph_total : 64) : 1;
				push_req(ACT_FIND, 4'($urandom), 16'($urandom), 17'(z),
					2'($urandom_range(0, 2)));
			end else begin
				push_req(2'($urandom), 4'($urandom), 16'($urandom), 17'($urandom),
					2'($urandom));
			end
		end
	endtask

	initial begin
		ph_idle = 0;
		ph_total = 1024;

		// directed, on the reset span of 1024
		push_req(ACT_FIND,   4'd0,  16'd0,     17'd1,     POL_FIRST);
		push_req(ACT_FIND,   4'd0,  16'd0,     17'd1024,  POL_BEST);
		push_req(ACT_FIND,   4'd0,  16'd0,     17'd1025,  POL_WORST);   // no fit
		push_req(ACT_FIND,   4'd0,  16'd0,     17'd0,     POL_FIRST);   // zero size
		push_req(ACT_FIND,   4'd0,  16'd0,     17'd4,     POL_BAD);     // bad policy
		push_req(ACT_BAD,    4'd15, 16'hFFFF,  17'h1FFFF, POL_BAD);     // bad action
		push_req(ACT_CREATE, 4'd0,  16'd0,     17'd0,     POL_FIRST);   // zero size
		push_req(ACT_CREATE, 4'd0,  16'd100,   17'd20,    POL_FIRST);   // middle split
		push_req(ACT_CREATE, 4'd0,  16'd300,   17'd5,     POL_FIRST);   // id in use
		push_req(ACT_CREATE, 4'd1,  16'd110,   17'd5,     POL_FIRST);   // not free
		push_req(ACT_CREATE, 4'd1,  16'd0,     17'd10,    POL_FIRST);   // trim front
		push_req(ACT_CREATE, 4'd2,  16'd1000,  17'd24,    POL_FIRST);   // trim tail
		push_req(ACT_CREATE, 4'd3,  16'd10,    17'd90,    POL_FIRST);   // exact fill
		push_req(ACT_CREATE, 4'd4,  16'hFFFF,  17'h1FFFF, POL_FIRST);   // beyond span
		push_req(ACT_FIND,   4'd0,  16'd0,     17'd1,     POL_BEST);
		push_req(ACT_FIND,   4'd0,  16'd0,     17'd1,     POL_WORST);
		push_req(ACT_REMOVE, 4'd9,  16'd0,     17'd0,     POL_FIRST);   // not found
		push_req(ACT_REMOVE, 4'd3,  16'd0,     17'd0,     POL_FIRST);   // no neighbour: insert
		push_req(ACT_REMOVE, 4'd0,  16'd0,     17'd0,     POL_FIRST);   // merge
		push_req(ACT_REMOVE, 4'd1,  16'd0,     17'd0,     POL_FIRST);
		push_req(ACT_REMOVE, 4'd2,  16'd0,     17'd0,     POL_FIRST);
		// full address space; top start and the largest size
		push_size(17'd65536, 0);
		push_req(ACT_FIND,   4'd0,  16'd0,     17'd65536, POL_WORST);
		push_req(ACT_CREATE, 4'd15, 16'hFFFF,  17'd1,     POL_FIRST);
		push_req(ACT_CREATE, 4'd14, 16'd0,     17'd65535, POL_FIRST);
		push_req(ACT_FIND,   4'd0,  16'd0,     17'd1,     POL_FIRST);   // empty table

		// random phases over several spans and idle rates
		push_size(17'd1024, 0);   push_random(250);
		push_size(17'd65536, 45); push_random(250);
		push_size(17'd1, 20);     push_random(120);
		push_size(17'd40, 0);     push_random(300);   // small span: table fills
		push_size(17'h1FFFF, 45); push_random(150);   // clips to the span
		push_size(17'd0, 20);     push_random(60);    // nothing free
		push_size(17'd300, 45);   push_random(250);
		push_size(17'd64, 20);    push_random(150);
		stim_loaded = 1;
	end

	// -------------------------------------------------------------------
	// End of run
	// -------------------------------------------------------------------
	initial begin
		wait (stim_loaded && arst_n);
		while (req_q.size() != 0 || answer_q.size() != 0 || start || busy || cfg_we)
			@(posedge clk);
		repeat (DRAIN_CYCLES) @(posedge clk);
		$display("Checked %0d results for %0d request beats across %0d size writes.",
			n_ans, n_req, n_size_wr);
		$display("Spans from empty to the full address space, idle rates 0/20/45 percent.");
		if (errors == 0 && answer_q.size() == 0) begin
			$display("All tests passed");
		end else begin
			$display("Some tests failed");
		end
		$finish;
	end

	initial begin
		#5_000_000;
		$display("Timeout with %0d beats pending", req_q.size());
		$display("Some tests failed");
		$finish;
	end

endmodule

FILE: filelist.f
rtl/sfla_pkg.sv
rtl/sfla_ram.sv
rtl/sfla_cell.sv
rtl/segment_free_list_allocator.sv
dv/tb_segment_free_list_allocator.sv
